// ===== sv/vtyp_pkg.sv =====
// vtyp_pkg: constants, arctangent table and shared types for vector_to_yaw_pitch.
// No dependencies.
package vtyp_pkg;

	localparam int GUARD_SHIFT = 28;
	localparam int ANG_W = 26;
	localparam logic signed [ANG_W-1:0] DEG90 = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG270 = 26'sd17694720;
	localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;
	localparam logic [29:0] GAIN_Q28 = 30'd442048841;

	typedef logic signed [ANG_W-1:0] angle_t;

	// atan(2^-i) in 1/65536 degree
	function automatic angle_t atan_tab(input int unsigned i);
		angle_t r;
		case (i)
			0: r = 26'sd2949120;
			1: r = 26'sd1740967;
			2: r = 26'sd919879;
			3: r = 26'sd466945;
			4: r = 26'sd234379;
			5: r = 26'sd117304;
			6: r = 26'sd58666;
			7: r = 26'sd29335;
			8: r = 26'sd14668;
			9: r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/vtyp_cordic.sv =====
// vtyp_cordic: pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on vtyp_pkg. Carries a sideband word alongside each beat.
module vtyp_cordic #(
	parameter int DW = 56,
	parameter int STAGES = 24,
	parameter int SBW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  logic signed [DW-1:0]     a_in,
	input  logic signed [DW-1:0]     b_in,
	input  vtyp_pkg::angle_t         ang_in,
	input  logic [SBW-1:0]           sb_in,
	output logic                     out_vld,
	output logic signed [DW-1:0]     a_out,
	output vtyp_pkg::angle_t         ang_out,
	output logic [SBW-1:0]           sb_out
);

	logic                   vld_s [STAGES+1];
	logic signed [DW-1:0]   a_s   [STAGES+1];
	logic signed [DW-1:0]   b_s   [STAGES+1];
	vtyp_pkg::angle_t       ang_s [STAGES+1];
	logic [SBW-1:0]         sb_s  [STAGES+1];

	assign vld_s[0] = in_vld;
	assign a_s[0] = a_in;
	assign b_s[0] = b_in;
	assign ang_s[0] = ang_in;
	assign sb_s[0] = sb_in;

	// one micro-rotation per stage; >>> floors, matching the model
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sb_s[i+1] <= sb_s[i];
				if (!b_s[i][DW-1]) begin
					a_s[i+1] <= a_s[i] + (b_s[i] >>> i);
					b_s[i+1] <= b_s[i] - (a_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] + vtyp_pkg::atan_tab(i);
				end else begin
					a_s[i+1] <= a_s[i] - (b_s[i] >>> i);
					b_s[i+1] <= b_s[i] + (a_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] - vtyp_pkg::atan_tab(i);
				end
			end
		end
	end

	assign out_vld = vld_s[STAGES];
	assign a_out = a_s[STAGES];
	assign ang_out = ang_s[STAGES];
	assign sb_out = sb_s[STAGES];

endmodule

// ===== sv/vector_to_yaw_pitch.sv =====
// vector_to_yaw_pitch: direction vector to yaw / pitch angles (1/65536 degree).
// Depends on vtyp_pkg and vtyp_cordic (two instances).
//
//  channel | beat fields                  | handshake
//  input   | x_coord y_coord z_coord      | in_valid / in_stall
//  output  | pitch_out yaw_out            | out_valid / out_stall
//
// One beat per cycle while out_stall does not hold the pipe. The pipe has 2*CORDIC_STAGES + 3
// register stages: a prerotate stage, the yaw CORDIC, a gain multiply stage, the pitch
// CORDIC and an output register.
// The whole pipe advances together whenever the output register is free or
// being drained; in_stall is out_stall gated by a full output register.
// Reset clears all valid bits; data registers are not reset.
module vector_to_yaw_pitch #(
	parameter int COORD_WIDTH = 24,
	parameter int CORDIC_STAGES = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic signed [COORD_WIDTH-1:0] z_coord,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [25:0]            pitch_out,
	output logic [24:0]                   yaw_out
);

	// datapath width: coordinate, guard bits, negation and CORDIC growth headroom
	localparam int DW = COORD_WIDTH + vtyp_pkg::GUARD_SHIFT + 4;
	localparam int SBW = COORD_WIDTH + 2;

	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: scale, negate x, prerotate left half plane
	logic                  vld_s1;
	logic signed [DW-1:0]  a_s1, b_s1;
	vtyp_pkg::angle_t      base_s1;
	logic [SBW-1:0]        sb_s1;
	logic signed [DW-1:0]  ax, bz;
	logic                  zero_vec;

	assign ax = -(DW'(x_coord) <<< vtyp_pkg::GUARD_SHIFT);
	assign bz = DW'(z_coord) <<< vtyp_pkg::GUARD_SHIFT;
	assign zero_vec = (x_coord == '0) && (z_coord == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s1 <= {zero_vec, (y_coord > 0), y_coord};
			if (ax[DW-1]) begin
				if (!bz[DW-1]) begin
					a_s1 <= bz;
					b_s1 <= -ax;
					base_s1 <= vtyp_pkg::DEG90;
				end else begin
					a_s1 <= -bz;
					b_s1 <= ax;
					base_s1 <= -vtyp_pkg::DEG90;
				end
			end else begin
				a_s1 <= ax;
				b_s1 <= bz;
				base_s1 <= '0;
			end
		end
	end

	// yaw CORDIC
	logic                  vld_y;
	logic signed [DW-1:0]  r_y;
	vtyp_pkg::angle_t      th_y;
	logic [SBW-1:0]        sb_y;

	vtyp_cordic #(.DW(DW), .STAGES(CORDIC_STAGES), .SBW(SBW)) u_yaw (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(vld_s1),
		.a_in(a_s1), .b_in(b_s1), .ang_in(base_s1), .sb_in(sb_s1),
		.out_vld(vld_y), .a_out(r_y), .ang_out(th_y), .sb_out(sb_y)
	);

	// stage 2: y times gain, wrap yaw
	logic                  vld_s2;
	logic signed [DW-1:0]  r_s2, yk_s2;
	logic [24:0]           yaw_s2;
	logic [1:0]            fl_s2;
	vtyp_pkg::angle_t      yw;
	logic signed [COORD_WIDTH+31:0] ymul;

	// theta lies in (-270, 270) degrees, so theta-90 is in (-360, 180)
	assign yw = th_y - vtyp_pkg::DEG90;
	assign ymul = $signed(sb_y[COORD_WIDTH-1:0]) * $signed({1'b0, vtyp_pkg::GAIN_Q28});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_y;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2 <= r_y;
			yk_s2 <= DW'(ymul);
			fl_s2 <= sb_y[SBW-1:SBW-2];
			yaw_s2 <= yw[vtyp_pkg::ANG_W-1] ? 25'(yw + vtyp_pkg::DEG360) : 25'(yw);
		end
	end

	// pitch CORDIC
	logic                  vld_p;
	logic signed [DW-1:0]  r_unused;
	vtyp_pkg::angle_t      ph_p;
	logic [26:0]           sb_p;

	vtyp_cordic #(.DW(DW), .STAGES(CORDIC_STAGES), .SBW(27)) u_pitch (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(vld_s2),
		.a_in(r_s2), .b_in(yk_s2), .ang_in('0), .sb_in({fl_s2, yaw_s2}),
		.out_vld(vld_p), .a_out(r_unused), .ang_out(ph_p), .sb_out(sb_p)
	);

	// output register: wrap and negate pitch, handle zero (x, z)
	vtyp_pkg::angle_t pw;
	always_comb begin
		if (sb_p[26]) begin
			pw = sb_p[25] ? vtyp_pkg::DEG90 : vtyp_pkg::DEG270;
		end else if (ph_p[vtyp_pkg::ANG_W-1]) begin
			pw = ph_p + vtyp_pkg::DEG360;
		end else begin
			pw = ph_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_p;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pitch_out <= -pw;
			yaw_out <= sb_p[26] ? '0 : sb_p[24:0];
		end
	end

	// checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(yaw_out) && $stable(pitch_out))
		else $error("output beat changed while stalled");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_out < 25'd23592960)
		else $error("yaw out of range");

endmodule

// ===== verif/vector_to_yaw_pitch_checker.sv =====
// Checker for vector_to_yaw_pitch: watches both channels, predicts angles, compares beats.
// Standalone; angle constants are local.
`timescale 1ns / 100ps
module vector_to_yaw_pitch_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [23:0] x_coord,
	input  logic signed [23:0] y_coord,
	input  logic signed [23:0] z_coord,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [25:0] pitch_out,
	input  logic [24:0]        yaw_out,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [25:0] pitch;
		logic [24:0]        yaw;
	} angles_t;

	localparam int STAGES = 24;
	localparam longint TURN = 64'sd23592960;
	localparam longint QUARTER = 64'sd5898240;

	angles_t angle_q[$];

	// arctangent of 2^-i, 1/65536 degree
	function automatic longint atan_step(int i);
		longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		if (i < 23) return t[i];
		return 0;
	endfunction

	// vectoring rotation; >>> on longint floors
	function automatic longint rotate_to_axis(inout longint a, inout longint b);
		longint ang, da, db;
		ang = 0;
		for (int i = 0; i < STAGES; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a += da; b -= db; ang += atan_step(i);
			end else begin
				a -= da; b += db; ang -= atan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic angles_t predict_angles(longint x, longint y, longint z);
		angles_t r;
		longint yaw, pitch, a, b, ta, base, yk;
		if (x == 0 && z == 0) begin
			yaw = 0;
			pitch = (y > 0) ? QUARTER : 3 * QUARTER;
		end else begin
			a = -x * (64'sd1 <<< 28);
			b = z * (64'sd1 <<< 28);
			base = 0;
			// left half plane: turn by a quarter first
			if (a < 0) begin
				ta = a;
				if (b >= 0) begin
					base = QUARTER; a = b; b = -ta;
				end else begin
					base = -QUARTER; a = -b; b = ta;
				end
			end
			yaw = (base + rotate_to_axis(a, b) - QUARTER) % TURN;
			if (yaw < 0) yaw += TURN;
			yk = y * 64'sd442048841;
			pitch = rotate_to_axis(a, yk);
			if (pitch < 0) pitch += TURN;
		end
		r.pitch = 26'(-pitch);
		r.yaw = 25'(yaw);
		return r;
	endfunction

	assign pending = angle_q.size();

	// predict on every accepted input beat, compare every accepted output beat
	always @(posedge clk or negedge arst_n) begin
		angles_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				angle_q.push_back(predict_angles(x_coord, y_coord, z_coord));
			if (out_valid && !out_stall) begin
				if (angle_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected beat pitch=%0d yaw=%0d",
						pitch_out, yaw_out);
					fail_count <= fail_count + 1;
				end else begin
					e = angle_q.pop_front();
					if (e.pitch !== pitch_out || e.yaw !== yaw_out) begin
						if (fail_count < 10)
							$display("mismatch pitch exp %0d got %0d, yaw exp %0d got %0d",
								e.pitch, pitch_out, e.yaw, yaw_out);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== verif/vector_to_yaw_pitch_tb.sv =====
// Testbench top for vector_to_yaw_pitch: directed and random vectors, random gaps and stalls.
// Depends on vector_to_yaw_pitch, vector_to_yaw_pitch_checker and vtyp_pkg.
`timescale 1ns / 100ps
module vector_to_yaw_pitch_tb;
	localparam int LATENCY = 2 * 24 + 4;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic signed [23:0] x_coord = '0, y_coord = '0, z_coord = '0;
	logic in_stall, out_valid;
	logic signed [25:0] pitch_out;
	logic [24:0] yaw_out;
	int fail_count, pending;
	longint cycles = 0;

	always #4 clk = ~clk;

	vector_to_yaw_pitch u_top (.*);
	vector_to_yaw_pitch_checker u_chk (.*);

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return 24'($signed($urandom_range(0, 16)) - 8);
			3: return '0;
			default: return 24'($urandom);
		endcase
	endfunction

	// valid drops only when a gap is drawn, so back-to-back beats hold it high
	task automatic send_vector(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		x_coord <= x; y_coord <= y; z_coord <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// receiver stalls; one long hold-off early on fills the pipe
	initial begin
		int w;
		repeat (40) @(posedge clk);
		out_stall <= 1;
		repeat (300) @(posedge clk);
		out_stall <= 0;
		@(posedge clk);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (w > 0) begin
				out_stall <= 1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [23:0] ext[4] = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// zero x and z: up, down, and zero y
		send_vector(24'd0, 24'd1, 24'd0);
		send_vector(24'd0, 24'hffffff, 24'd0);
		send_vector(24'd0, 24'd0, 24'd0);
		// extremes and all four quadrants
		foreach (ext[i]) foreach (ext[j]) send_vector(ext[i], ext[j], ext[(i + j) % 4]);
		send_vector(24'd5, 24'd3, 24'd0);
		send_vector(24'hfffffb, 24'd3, 24'd0);
		send_vector(24'd0, 24'd3, 24'd7);
		send_vector(24'd0, 24'd3, 24'hfffff9);
		for (int n = 0; n < 650; n++) send_vector(rand_coord(), rand_coord(), rand_coord());
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
